### rtl/wmrs_pkg.sv
// Package for the washer motor relay sequencer.
// Holds pin positions, phase and spin codes, register indexes and shared structs.
// No dependencies.
package wmrs_pkg;

    localparam int PIN_VALVE = 0;
    localparam int PIN_DIR   = 1;
    localparam int PIN_SPD1  = 2;
    localparam int PIN_SPD2  = 3;
    localparam int PIN_PUMP  = 4;
    localparam int PIN_MOTOR = 5;
    localparam int NUM_PINS  = 6;

    localparam logic [2:0] FN_FILL_PREWASH = 3'd0;
    localparam logic [2:0] FN_FILL_WASH    = 3'd1;
    localparam logic [2:0] FN_FILL         = 3'd2;
    localparam logic [2:0] FN_FILL_SOFT    = 3'd3;
    localparam logic [2:0] FN_WASH         = 3'd4;
    localparam logic [2:0] FN_DRAIN        = 3'd5;
    localparam logic [2:0] FN_SPIN         = 3'd6;
    localparam logic [2:0] FN_OTHER        = 3'd7;

    localparam logic [2:0] SPIN_IDLE   = 3'd0;
    localparam logic [2:0] SPIN_SETTLE = 3'd1;
    localparam logic [2:0] SPIN_RUN    = 3'd2;
    localparam logic [2:0] SPIN_STOP   = 3'd3;
    localparam logic [2:0] SPIN_SPEED  = 3'd4;
    localparam logic [2:0] SPIN_DIR    = 3'd5;
    localparam logic [2:0] SPIN_DONE   = 3'd6;
    localparam logic [2:0] SPIN_HOLD   = 3'd7;

    localparam logic       OP_REFRESH    = 1'b0;
    localparam logic       OP_SPIN_RESET = 1'b1;

    localparam logic [2:0] CFG_SETTLE    = 3'd0;
    localparam logic [2:0] CFG_MOTOR_ON  = 3'd1;
    localparam logic [2:0] CFG_MOTOR_OFF = 3'd2;
    localparam logic [2:0] CFG_SPEED     = 3'd3;
    localparam logic [2:0] CFG_DIRECTION = 3'd4;

    localparam logic [15:0] RST_SETTLE    = 16'd1000;
    localparam logic [15:0] RST_MOTOR_ON  = 16'd3000;
    localparam logic [15:0] RST_MOTOR_OFF = 16'd10;
    localparam logic [15:0] RST_SPEED     = 16'd10;
    localparam logic [15:0] RST_DIRECTION = 16'd100;

    typedef struct packed {
        logic        operation;
        logic [31:0] now_ms;
        logic        machine_on;
        logic        phase_valid;
        logic [2:0]  phase_function;
        logic [7:0]  wash_step;
        logic        drum_empty;
        logic        already_accelerated;
    } t_item;

    typedef struct packed {
        logic [NUM_PINS-1:0] pins;
        logic [2:0]          state;
        logic [31:0]         deadline;
    } t_seq;

    typedef struct packed {
        logic [15:0] settle;
        logic [15:0] motor_on;
        logic [15:0] motor_off;
        logic [15:0] speed;
        logic [15:0] direction;
    } t_waits;

    typedef struct packed {
        logic [NUM_PINS-1:0] pins;
        logic                set_accelerated;
        logic                step_forced_zero;
    } t_result;

endpackage

### rtl/wmrs_step.sv
// Next-state logic of the washer motor relay sequencer for one transaction.
// Pure combinational; uses wmrs_pkg.
module wmrs_step
    import wmrs_pkg::*;
(
    input  t_item   i_item,
    input  t_seq    i_seq,
    input  t_waits  i_waits,
    output t_seq    o_seq,
    output t_result o_result
);

    t_seq                n_seq;
    logic [NUM_PINS-1:0] pins;
    logic [7:0]          step;
    logic                forced;
    logic                accel_done;
    logic                agitate;

    always_comb begin
        n_seq      = i_seq;
        pins       = i_seq.pins;
        forced     = 1'b0;
        accel_done = 1'b0;
        agitate    = 1'b0;
        step       = i_item.wash_step;

        if (i_item.operation == OP_SPIN_RESET) begin
            n_seq.state    = SPIN_IDLE;
            n_seq.deadline = 32'd0;
        end else if (i_item.machine_on && i_item.phase_valid) begin
            if (i_item.phase_function != FN_SPIN) begin
                n_seq.state = SPIN_IDLE;
            end
            case (i_item.phase_function)
                FN_FILL_PREWASH, FN_FILL_WASH: begin
                    if (!i_item.drum_empty) begin
                        agitate = 1'b1;
                    end else begin
                        pins[PIN_MOTOR] = 1'b1;
                        pins[PIN_DIR]   = 1'b1;
                        pins[PIN_SPD1]  = 1'b1;
                        pins[PIN_SPD2]  = 1'b1;
                    end
                end
                FN_WASH: begin
                    pins[PIN_VALVE] = 1'b1;
                    agitate         = 1'b1;
                end
                FN_DRAIN: begin
                    pins[PIN_VALVE] = 1'b1;
                    pins[PIN_DIR]   = 1'b1;
                    pins[PIN_SPD1]  = 1'b1;
                    pins[PIN_SPD2]  = 1'b1;
                    pins[PIN_MOTOR] = 1'b1;
                    pins[PIN_PUMP]  = 1'b0;
                end
                FN_SPIN: begin
                    if (i_item.already_accelerated) begin
                        pins = '0;
                        pins[PIN_VALVE] = 1'b1;
                    end else if (i_seq.state == SPIN_IDLE) begin
                        pins[PIN_VALVE] = 1'b1;
                        pins[PIN_DIR]   = 1'b0;
                        pins[PIN_SPD1]  = 1'b1;
                        pins[PIN_SPD2]  = 1'b1;
                        n_seq.deadline  = i_item.now_ms + {16'd0, i_waits.settle};
                        n_seq.state     = SPIN_SETTLE;
                    end else if (i_seq.state inside {SPIN_DONE, SPIN_HOLD}) begin
                        pins[PIN_SPD1]  = 1'b0;
                        pins[PIN_SPD2]  = 1'b0;
                        pins[PIN_PUMP]  = 1'b0;
                        pins[PIN_MOTOR] = 1'b0;
                    end else if (i_item.now_ms >= i_seq.deadline) begin
                        case (i_seq.state)
                            SPIN_SETTLE: begin
                                pins[PIN_MOTOR] = 1'b0;
                                n_seq.deadline  = i_item.now_ms + {16'd0, i_waits.motor_on};
                                n_seq.state     = SPIN_RUN;
                            end
                            SPIN_RUN: begin
                                pins[PIN_MOTOR] = 1'b1;
                                n_seq.deadline  = i_item.now_ms + {16'd0, i_waits.motor_off};
                                n_seq.state     = SPIN_STOP;
                            end
                            SPIN_STOP: begin
                                pins[PIN_SPD1]  = 1'b0;
                                pins[PIN_SPD2]  = 1'b0;
                                n_seq.deadline  = i_item.now_ms + {16'd0, i_waits.speed};
                                n_seq.state     = SPIN_SPEED;
                            end
                            SPIN_SPEED: begin
                                pins[PIN_DIR]   = 1'b0;
                                n_seq.deadline  = i_item.now_ms + {16'd0, i_waits.direction};
                                n_seq.state     = SPIN_DIR;
                            end
                            default: begin
                                pins[PIN_MOTOR] = 1'b0;
                                n_seq.state     = SPIN_DONE;
                                accel_done      = 1'b1;
                            end
                        endcase
                    end
                end
                default: begin
                end
            endcase

            if (agitate) begin
                if (step >= 8'd4) begin
                    step   = 8'd0;
                    forced = 1'b1;
                end
                if (step inside {8'd1, 8'd3}) begin
                    pins[PIN_MOTOR] = 1'b1;
                end else begin
                    pins[PIN_SPD1]  = 1'b1;
                    pins[PIN_SPD2]  = 1'b1;
                    pins[PIN_PUMP]  = 1'b1;
                    pins[PIN_DIR]   = (step == 8'd0);
                    pins[PIN_MOTOR] = 1'b0;
                end
            end
        end
        n_seq.pins = pins;
    end

    assign o_seq                     = n_seq;
    assign o_result.pins             = pins;
    assign o_result.set_accelerated  = accel_done;
    assign o_result.step_forced_zero = forced;

endmodule

### rtl/washer_motor_relay_sequencer.sv
// Top level of the washer motor relay sequencer: input register, state, result register.
// Depends on wmrs_pkg and wmrs_step.
//
//   channel  | handshake            | payload
//   ---------+----------------------+------------------------------------------
//   input    | i_valid / o_ready    | i_operation .. i_already_accelerated
//   result   | o_valid / i_ready    | o_valve_pin .. o_step_forced_zero
//   config   | i_cfg_we             | i_cfg_index, i_cfg_data
//
// One transaction per cycle while the result is not stalled; the result passes through the
// input register, then the result register.
// The relay state updates in the same cycle that loads the result register.
// A stalled result holds the input register; o_ready falls only when both are full and the result is stalled.
// Synchronous active-low reset clears the relay state and loads the default waits.
module washer_motor_relay_sequencer
    import wmrs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_operation,
    input  logic [31:0] i_now_ms,
    input  logic        i_machine_on,
    input  logic        i_phase_valid,
    input  logic [2:0]  i_phase_function,
    input  logic [7:0]  i_wash_step,
    input  logic        i_drum_empty,
    input  logic        i_already_accelerated,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_valve_pin,
    output logic        o_direction_pin,
    output logic        o_speed1_pin,
    output logic        o_speed2_pin,
    output logic        o_pump_pin,
    output logic        o_motor_pin,
    output logic        o_set_accelerated,
    output logic        o_step_forced_zero,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    logic    r_in_valid;
    t_item   r_item;
    logic    r_out_valid;
    t_result r_result;
    t_seq    r_seq;
    t_waits  r_waits;
    t_seq    n_seq;
    t_result n_result;
    logic    advance;

    assign advance = !r_out_valid || i_ready;
    assign o_ready = !r_in_valid || advance;

    wmrs_step u_step (
        .i_item   (r_item),
        .i_seq    (r_seq),
        .i_waits  (r_waits),
        .o_seq    (n_seq),
        .o_result (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_waits.settle    <= RST_SETTLE;
            r_waits.motor_on  <= RST_MOTOR_ON;
            r_waits.motor_off <= RST_MOTOR_OFF;
            r_waits.speed     <= RST_SPEED;
            r_waits.direction <= RST_DIRECTION;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_SETTLE:    r_waits.settle    <= i_cfg_data;
                CFG_MOTOR_ON:  r_waits.motor_on  <= i_cfg_data;
                CFG_MOTOR_OFF: r_waits.motor_off <= i_cfg_data;
                CFG_SPEED:     r_waits.speed     <= i_cfg_data;
                CFG_DIRECTION: r_waits.direction <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item.operation           <= i_operation;
            r_item.now_ms              <= i_now_ms;
            r_item.machine_on          <= i_machine_on;
            r_item.phase_valid         <= i_phase_valid;
            r_item.phase_function      <= i_phase_function;
            r_item.wash_step           <= i_wash_step;
            r_item.drum_empty          <= i_drum_empty;
            r_item.already_accelerated <= i_already_accelerated;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq       <= '0;
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
            if (r_in_valid) begin
                r_seq <= n_seq;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_valid) begin
            r_result <= n_result;
        end
    end

    assign o_valid            = r_out_valid;
    assign o_valve_pin        = r_result.pins[PIN_VALVE];
    assign o_direction_pin    = r_result.pins[PIN_DIR];
    assign o_speed1_pin       = r_result.pins[PIN_SPD1];
    assign o_speed2_pin       = r_result.pins[PIN_SPD2];
    assign o_pump_pin         = r_result.pins[PIN_PUMP];
    assign o_motor_pin        = r_result.pins[PIN_MOTOR];
    assign o_set_accelerated  = r_result.set_accelerated;
    assign o_step_forced_zero = r_result.step_forced_zero;

endmodule
